/* hdl/bba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  // Result codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SIZE     = 2'd1,
    ST_NOFREE   = 2'd2,
    ST_NOTALLOC = 2'd3
  } status_e;

  // Request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] request_size;
    logic [31:0] free_address;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] block_address;
    logic [12:0] block_size;
  } out_t;

  // One tree node as stored in the mark memory
  typedef struct packed {
    logic taken;
    logic below;
  } ent_t;

  // Controller to datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic rd_sib;
    logic a_step;
    logic mark;
    logic f_step;
    logic up_write;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic err;
    logic op_free;
    logic found;
    logic fail;
    logic rd_taken;
    logic at_root;
    logic lvl_one;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* hdl/buddy_block_allocator.sv */
// An allocate runs a left-first search over the tree for a free node at the target level,
//   marks it taken and walks back up; a free climbs from the leaf to the taken node,
//   clears it and walks back up. One word is in flight at a time, and each walk reads
//   one node at a time from the mark memory.
// Reset: asynchronous, active low; pool_base returns to 0 and a clearing pass over every
//   mark memory entry precedes the first word.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator #(
  parameter int POOL_BYTES      = 4096,
  parameter int MIN_BLOCK_BYTES = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         pool_base_we_i,
  input  wire logic [31:0]  pool_base_i,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire bba_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output bba_pkg::out_t     out_data_o
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_dp #(
    .POOL_BYTES      (POOL_BYTES),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pool_base_we_i (pool_base_we_i),
    .pool_base_i    (pool_base_i),
    .in_data_i      (in_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  // One word in flight at a time
  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !in_ready_o)
    else $error("input taken while a word is in flight");

  // Memory writers never collide
  a_one_writer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr, cmd.mark, cmd.f_step, cmd.up_write}))
    else $error("two memory writers in one cycle");

  // A good result names a block, a failure names none
  a_size_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.status == ST_OK) == (out_data_o.block_size != 13'd0)))
    else $error("block size disagrees with status");

  // Nothing is accepted during the clearing pass
  a_no_load_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> !in_ready_o)
    else $error("ready during clearing pass");

endmodule
`default_nettype wire

/* hdl/bba_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
  parameter int W     = 2,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* hdl/bba_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bba_pkg::sts_t sts_i,
  output bba_pkg::cmd_t      cmd_o
);
  import bba_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_CHK   = 11'b000_0000_0100,
    S_A_RD  = 11'b000_0000_1000,
    S_A_EV  = 11'b000_0001_0000,
    S_MARK  = 11'b000_0010_0000,
    S_U_RD  = 11'b000_0100_0000,
    S_U_WR  = 11'b000_1000_0000,
    S_F_RD  = 11'b001_0000_0000,
    S_F_EV  = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Sequence one request: search or climb, mark or clear, walk up
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.err)          state_d = S_FIN;
        else if (sts_i.op_free) state_d = S_F_RD;
        else                    state_d = S_A_RD;
      end
      S_A_RD: state_d = S_A_EV;
      S_A_EV: begin
        cmd_o.a_step = 1'b1;
        if (sts_i.found)     state_d = S_MARK;
        else if (sts_i.fail) state_d = S_FIN;
        else                 state_d = S_A_RD;
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        state_d    = sts_i.at_root ? S_FIN : S_U_RD;
      end
      S_U_RD: begin
        cmd_o.rd_sib = 1'b1;
        state_d      = S_U_WR;
      end
      S_U_WR: begin
        cmd_o.up_write = 1'b1;
        state_d        = sts_i.lvl_one ? S_FIN : S_U_RD;
      end
      S_F_RD: state_d = S_F_EV;
      S_F_EV: begin
        cmd_o.f_step = 1'b1;
        if (sts_i.at_root)       state_d = S_FIN;
        else if (sts_i.rd_taken) state_d = S_U_RD;
        else                     state_d = S_F_RD;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/bba_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module bba_dp #(
  parameter int POOL_BYTES      = 4096,
  parameter int MIN_BLOCK_BYTES = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          pool_base_we_i,
  input  wire logic [31:0]   pool_base_i,
  input  wire bba_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output bba_pkg::out_t      out_data_o,
  input  wire bba_pkg::cmd_t cmd_i,
  output bba_pkg::sts_t      sts_o
);
  import bba_pkg::*;

  localparam int LOG_POOL = $clog2(POOL_BYTES);
  localparam int LOG_MIN  = $clog2(MIN_BLOCK_BYTES);
  localparam int LEAF_LVL = LOG_POOL - LOG_MIN;
  localparam int NW       = LEAF_LVL + 1;
  localparam int LW       = $clog2(LEAF_LVL + 1);

  logic [31:0]   pool_base_q;
  logic [NW-1:0] node_q, clr_cnt_q;
  logic [LW-1:0] lvl_q, tgt_q;
  logic          op_q, carry_t_q, carry_b_q;
  status_e       res_q;
  logic [31:0]   blk_addr_q;
  logic [12:0]   blk_size_q;
  out_t          out_q;
  logic          out_valid_q;

  ent_t          rd_ent, wr_ent;
  logic          ram_we;
  logic [NW-1:0] ram_waddr, ram_raddr;

  // Request size to tree level
  logic [4:0] clog, lg;
  logic       oversize;
  logic [5:0] tgt_full;
  always_comb begin
    clog = '0;
    for (int k = 0; k < 16; k++) begin
      if ((17'(1) << k) < {1'b0, in_data_i.request_size}) clog = clog + 5'd1;
    end
    lg       = (clog < 5'(LOG_MIN)) ? 5'(LOG_MIN) : clog;
    oversize = lg > 5'(LOG_POOL);
    tgt_full = 6'(LOG_POOL) - {1'b0, lg};
  end

  // Free address to leaf
  logic [31:0]   foff;
  logic          fbad;
  logic [NW-1:0] leaf;
  assign foff = in_data_i.free_address - pool_base_q;
  assign fbad = (foff >> LOG_POOL) != 32'd0;
  assign leaf = {1'b1, foff[LOG_POOL-1:LOG_MIN]};

  // Next node in left-first order after skipping this subtree
  logic [NW:0]   m;
  logic [LW-1:0] tz;
  logic          rightmost;
  logic [NW-1:0] skip_node, jump_node;
  always_comb begin
    m  = {1'b0, node_q} + (NW+1)'(1);
    tz = '0;
    for (int k = 1; k <= NW; k++) begin
      if ((m & (((NW+1)'(1) << k) - (NW+1)'(1))) == '0) tz = tz + LW'(1);
    end
    rightmost = m == ((NW+1)'(2) << lvl_q);
    skip_node = NW'(m >> tz);
    jump_node = node_q << (tgt_q - lvl_q);
  end

  logic found, descend;
  assign found   = !rd_ent.taken && !rd_ent.below;
  assign descend = !found && !rd_ent.taken && (lvl_q < tgt_q);

  // Block start offset and size of the current node
  logic [NW-1:0] leafi;
  logic [31:0]   node_off;
  logic [12:0]   node_size;
  assign leafi     = node_q << (LW'(LEAF_LVL) - lvl_q);
  assign node_off  = 32'(leafi[NW-2:0]) << LOG_MIN;
  assign node_size = 13'(32'(POOL_BYTES) >> lvl_q);

  // Marks for the parent on the upward walk
  logic up_t, up_b;
  assign up_t = (op_q == ACT_ALLOC) ? (carry_t_q & rd_ent.taken) : 1'b0;
  assign up_b = (op_q == ACT_ALLOC) ? 1'b1 : (carry_b_q | rd_ent.taken | rd_ent.below);

  // Memory write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node_q;
    wr_ent    = '0;
    if (cmd_i.clr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
    end else if (cmd_i.mark) begin
      ram_we = 1'b1;
      wr_ent = '{taken: 1'b1, below: 1'b0};
    end else if (cmd_i.f_step && rd_ent.taken) begin
      ram_we = 1'b1;
      wr_ent = '{taken: 1'b0, below: rd_ent.below};
    end else if (cmd_i.up_write) begin
      ram_we    = 1'b1;
      ram_waddr = node_q >> 1;
      wr_ent    = '{taken: up_t, below: up_b};
    end
  end

  assign ram_raddr = cmd_i.rd_sib ? (node_q ^ NW'(1)) : node_q;

  bba_ram #(
    .W     ($bits(ent_t)),
    .DEPTH (2 ** NW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_ent),
    .raddr_i (ram_raddr),
    .rdata_o (rd_ent)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pool_base_we_i) pool_base_q <= pool_base_i;
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + NW'(1);
      if (cmd_i.out_load)  out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Walk registers and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= in_data_i.action;
      blk_addr_q <= '0;
      blk_size_q <= '0;
      if (in_data_i.action == ACT_ALLOC) begin
        node_q <= NW'(1);
        lvl_q  <= '0;
        tgt_q  <= LW'(tgt_full);
        res_q  <= oversize ? ST_SIZE : ST_OK;
      end else begin
        node_q <= leaf;
        lvl_q  <= LW'(LEAF_LVL);
        tgt_q  <= LW'(LEAF_LVL);
        res_q  <= fbad ? ST_NOTALLOC : ST_OK;
      end
    end
    if (cmd_i.a_step) begin
      if (found) begin
        node_q <= jump_node;
        lvl_q  <= tgt_q;
      end else if (descend) begin
        node_q <= {node_q[NW-2:0], 1'b0};
        lvl_q  <= lvl_q + LW'(1);
      end else if (rightmost) begin
        res_q <= ST_NOFREE;
      end else begin
        node_q <= skip_node;
        lvl_q  <= lvl_q - tz;
      end
    end
    if (cmd_i.mark) begin
      carry_t_q  <= 1'b1;
      blk_addr_q <= pool_base_q + node_off;
      blk_size_q <= node_size;
    end
    if (cmd_i.f_step) begin
      if (rd_ent.taken) begin
        carry_b_q  <= rd_ent.below;
        blk_addr_q <= pool_base_q + node_off;
        blk_size_q <= node_size;
      end else if (lvl_q == '0) begin
        res_q <= ST_NOTALLOC;
      end else begin
        node_q <= node_q >> 1;
        lvl_q  <= lvl_q - LW'(1);
      end
    end
    if (cmd_i.up_write) begin
      node_q    <= node_q >> 1;
      lvl_q     <= lvl_q - LW'(1);
      carry_t_q <= up_t;
      carry_b_q <= up_b;
    end
    if (cmd_i.out_load) begin
      out_q.status        <= res_q;
      out_q.block_address <= (res_q == ST_OK) ? blk_addr_q : 32'd0;
      out_q.block_size    <= (res_q == ST_OK) ? blk_size_q : 13'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o          = '0;
    sts_o.clr_last = &clr_cnt_q;
    sts_o.err      = res_q != ST_OK;
    sts_o.op_free  = op_q == ACT_FREE;
    sts_o.found    = found;
    sts_o.fail     = !found && !descend && rightmost;
    sts_o.rd_taken = rd_ent.taken;
    sts_o.at_root  = lvl_q == '0;
    sts_o.lvl_one  = lvl_q == LW'(1);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule
`default_nettype wire
